### rtl/sync_frame_xor_deframer_assert.svh
// assertion macros for the sync frame xor deframer
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef SYNC_FRAME_XOR_DEFRAMER_ASSERT_SVH
`define SYNC_FRAME_XOR_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// property holds in the same cycle
`define SFX_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// property holds in the next cycle
`define SFX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFX_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define SFX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/sfx_pkg.sv
// shared types and constants for the sync frame xor deframer
// no dependencies
package sfx_pkg;

    localparam int unsigned AddrWidth = 4;
    localparam int unsigned DataWidth = 32;

    typedef enum logic [1:0] {
        REG_FIRST_SYNC   = 2'd0,
        REG_SECOND_SYNC  = 2'd1,
        REG_FRAME_TYPE   = 2'd2,
        REG_FRAME_LENGTH = 2'd3
    } reg_idx_t;

    localparam logic [7:0] FirstSyncRst   = 8'd170;
    localparam logic [7:0] SecondSyncRst  = 8'd85;
    localparam logic [7:0] FrameTypeRst   = 8'd2;
    localparam logic [7:0] FrameLengthRst = 8'd32;
    localparam logic [7:0] MinLength      = 8'd2;

    typedef enum logic [1:0] {
        PH_SYNC0 = 2'd0,
        PH_SYNC1 = 2'd1,
        PH_TYPE  = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] first_sync;
        logic [7:0] second_sync;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       frame_end;
        logic       frame_good;
    } result_t;

endpackage

### rtl/sfx_cfg.sv
// apb register file for the four frame settings
// depends on sfx_pkg
module sfx_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfx_pkg::AddrWidth-1:0] paddr,
    input  logic [sfx_pkg::DataWidth-1:0] pwdata,
    output logic [sfx_pkg::DataWidth-1:0] prdata,
    output sfx_pkg::cfg_t                 cfg
);
    import sfx_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[AddrWidth-1:2]);
    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FIRST_SYNC:   cfg_next.first_sync   = pwdata[7:0];
                REG_SECOND_SYNC:  cfg_next.second_sync  = pwdata[7:0];
                REG_FRAME_TYPE:   cfg_next.frame_type   = pwdata[7:0];
                REG_FRAME_LENGTH: cfg_next.frame_length = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_sync   <= FirstSyncRst;
            cfg_reg.second_sync  <= SecondSyncRst;
            cfg_reg.frame_type   <= FrameTypeRst;
            cfg_reg.frame_length <= FrameLengthRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FIRST_SYNC:   prdata = {{(DataWidth-8){1'b0}}, cfg_reg.first_sync};
            REG_SECOND_SYNC:  prdata = {{(DataWidth-8){1'b0}}, cfg_reg.second_sync};
            REG_FRAME_TYPE:   prdata = {{(DataWidth-8){1'b0}}, cfg_reg.frame_type};
            REG_FRAME_LENGTH: prdata = {{(DataWidth-8){1'b0}}, cfg_reg.frame_length};
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### rtl/sfx_step.sv
// hunt state machine, byte counter and xor accumulator; one byte per step
// depends on sfx_pkg
module sfx_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  sfx_pkg::cfg_t    cfg,
    output sfx_pkg::result_t res
);
    import sfx_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic [7:0] len;
    logic [7:0] count_inc;

    // lengths below two behave as two
    assign len       = (cfg.frame_length < MinLength) ? MinLength : cfg.frame_length;
    assign count_inc = (count_reg == 8'hff) ? count_reg : count_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC0;
            count_reg <= '0;
            xor_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        res        = '0;
        unique case (phase_reg)
            PH_SYNC0:
            begin
                if (rx_byte == cfg.first_sync)
                    phase_next = PH_SYNC1;
            end
            PH_SYNC1:
            begin
                phase_next = (rx_byte == cfg.second_sync) ? PH_TYPE : PH_SYNC0;
            end
            PH_TYPE:
            begin
                if (rx_byte == cfg.frame_type)
                begin
                    phase_next    = PH_BODY;
                    count_next    = 8'd1;
                    xor_next      = rx_byte;
                    res.valid     = 1'b1;
                    res.data_byte = rx_byte;
                end
                else
                begin
                    phase_next = PH_SYNC0;
                end
            end
            PH_BODY:
            begin
                res.valid = 1'b1;
                if (count_inc >= len)
                begin
                    // checksum byte closes the frame
                    phase_next     = PH_SYNC0;
                    count_next     = '0;
                    xor_next       = '0;
                    res.frame_end  = 1'b1;
                    res.frame_good = (rx_byte == xor_reg);
                end
                else
                begin
                    count_next    = count_inc;
                    xor_next      = xor_reg ^ rx_byte;
                    res.data_byte = rx_byte;
                end
            end
            default:
            begin
                phase_next = PH_SYNC0;
            end
        endcase
    end

endmodule

### rtl/sync_frame_xor_deframer.sv
// sync frame xor deframer: each word is registered at the input, its result at the output
// one word per cycle when m_tready holds; the input register feeds the state step and the
// result register in a single cycle, the output register parts the two handshakes
// words that only hunt for sync give no result
// asynchronous active-low reset clears hunt state and handshakes; settings go to defaults
`include "sync_frame_xor_deframer_assert.svh"

module sync_frame_xor_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sfx_pkg::AddrWidth-1:0] paddr,
    input  logic [sfx_pkg::DataWidth-1:0] pwdata,
    output logic [sfx_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // [7:0] data_byte
    output logic                          m_tlast,  // frame_end
    output logic [0:0]                    m_tuser   // [0] frame_good
);
    import sfx_pkg::*;

    cfg_t       cfg;
    result_t    res;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_good_reg;
    logic       advance;
    logic       in_take;

    sfx_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // held word moves on when the result register is free or being drained
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign in_take  = s_tvalid & s_tready;

    sfx_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign in_valid_next  = in_take | (in_valid_reg & ~advance);
    assign out_valid_next = advance ? res.valid : (out_valid_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= s_tdata;
        if (advance && res.valid)
        begin
            out_data_reg <= res.data_byte;
            out_last_reg <= res.frame_end;
            out_good_reg <= res.frame_good;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_good_reg;

    `SFX_ASSERT_NOW(a_good_only_at_end, clk, rst_n, m_tvalid && m_tuser[0], m_tlast, "frame_good set on a word that does not end a frame")
    `SFX_ASSERT_NOW(a_end_data_zero, clk, rst_n, m_tvalid && m_tlast, m_tdata == 8'd0, "end word carries nonzero data")
    `SFX_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !in_valid_reg, s_tready, "input stage empty but not ready")
    `SFX_ASSERT_NEXT(a_stall_keeps_input, clk, rst_n, in_valid_reg && out_valid_reg && !m_tready, in_valid_reg, "held input word lost during output stall")

endmodule

### bench/sync_frame_xor_deframer_tb.sv
// self-checking bench for sync_frame_xor_deframer: byte stream in, frame words out
// depends on sfx_pkg and the rtl top; a built-in predictor tracks sync hunt, count and xor
// directed hunting and framing cases, then random frames under varied settings, then streaming

module sync_frame_xor_deframer_tb;

    import sfx_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_LIMIT  = 5000;
    // random phases stop here; the streaming test adds the rest of the run
    localparam int TARGET_WORDS = 1770;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic       frame_good;
    } frame_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [DataWidth-1:0] pwdata = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    sync_frame_xor_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // predictor copy of the registers and the hunt state
    logic [7:0] cfg_first  = FirstSyncRst;
    logic [7:0] cfg_second = SecondSyncRst;
    logic [7:0] cfg_type   = FrameTypeRst;
    logic [7:0] cfg_len    = FrameLengthRst;
    phase_t     deframe_phase = PH_SYNC0;
    logic [7:0] frame_bytes = 8'd0;
    logic [7:0] xor_acc = 8'd0;

    frame_word_t expected_words[$];

    int fail_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int frames_good = 0;
    int frames_bad = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    bit tx_stall_on = 1'b0;
    bit rx_stall_on = 1'b0;
    int hold_req = 0;
    int hold_left = 0;
    int rx_gap = 0;

    function automatic bit predict_word(input logic [7:0] b, output frame_word_t w);
        logic [7:0] eff_len;
        eff_len = (cfg_len < MinLength) ? MinLength : cfg_len;
        w = '0;
        predict_word = 1'b0;
        case (deframe_phase)
            PH_SYNC0:
            begin
                if (b == cfg_first)
                    deframe_phase = PH_SYNC1;
            end
            PH_SYNC1:
            begin
                deframe_phase = (b == cfg_second) ? PH_TYPE : PH_SYNC0;
            end
            PH_TYPE:
            begin
                if (b != cfg_type)
                begin
                    deframe_phase = PH_SYNC0;
                end
                else
                begin
                    xor_acc = b;
                    frame_bytes = 8'd1;
                    deframe_phase = PH_BODY;
                    w.data_byte = b;
                    predict_word = 1'b1;
                end
            end
            default:
            begin
                if (frame_bytes != 8'hFF)
                    frame_bytes = frame_bytes + 8'd1;
                if (frame_bytes >= eff_len)
                begin
                    w.frame_end = 1'b1;
                    w.frame_good = (b == xor_acc);
                    deframe_phase = PH_SYNC0;
                    frame_bytes = 8'd0;
                    xor_acc = 8'd0;
                end
                else
                begin
                    xor_acc = xor_acc ^ b;
                    w.data_byte = b;
                end
                predict_word = 1'b1;
            end
        endcase
    endfunction

    // receiver: random stall bursts, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (rx_gap != 0)
        begin
            m_tready <= 1'b0;
            rx_gap--;
        end
        else if (rx_stall_on && $urandom_range(0, 6) == 0)
        begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 8);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_word
        frame_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with none expected: data_byte %0h frame_end %0b",
                       m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (m_tdata !== exp_w.data_byte)
                begin
                    $error("data_byte mismatch: expected %0h actual %0h",
                           exp_w.data_byte, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== exp_w.frame_end)
                begin
                    $error("frame_end mismatch: expected %0b actual %0b",
                           exp_w.frame_end, m_tlast);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_w.frame_good)
                begin
                    $error("frame_good mismatch: expected %0b actual %0b",
                           exp_w.frame_good, m_tuser[0]);
                    fail_count++;
                end
                results_checked++;
                if (exp_w.frame_end)
                begin
                    if (exp_w.frame_good)
                        frames_good++;
                    else
                        frames_bad++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("** sync_frame_xor_deframer: FAILED **");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b);
        frame_word_t w;
        int gap;
        if (tx_stall_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        // tready only moves at rising edges, so the falling edge shows the next edge's value
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
        if (predict_word(b, w))
            expected_words.push_back(w);
    endtask

    task automatic wait_drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_words.size() != 0)
        begin
            $error("%0d expected result words never arrived", expected_words.size());
            fail_count++;
            expected_words.delete();
        end
        // words that only hunt give no result, so let the pipeline empty
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
        case (idx)
            REG_FIRST_SYNC:   cfg_first = val;
            REG_SECOND_SYNC:  cfg_second = val;
            REG_FRAME_TYPE:   cfg_type = val;
            REG_FRAME_LENGTH: cfg_len = val;
            default:          ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] f, input logic [7:0] s,
                              input logic [7:0] t, input logic [7:0] l);
        wait_drain();
        write_reg(REG_FIRST_SYNC, f);
        write_reg(REG_SECOND_SYNC, s);
        write_reg(REG_FRAME_TYPE, t);
        write_reg(REG_FRAME_LENGTH, l);
    endtask

    task automatic send_frame(input int body_len, input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        send_word(cfg_first);
        send_word(cfg_second);
        send_word(cfg_type);
        sum = cfg_type;
        repeat (body_len)
        begin
            b = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            send_word(b);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_word(sum);
    endtask

    function automatic int body_for_len();
        return (cfg_len < MinLength) ? 0 : int'(cfg_len) - 2;
    endfunction

    task automatic test_hunting();
        // wrong second sync, wrong type, and a bad second sync that is not retried as first
        send_word(cfg_first);
        send_word(8'h00);
        send_word(cfg_first);
        send_word(cfg_second);
        send_word(cfg_type ^ 8'h01);
        send_word(cfg_first);
        send_word(cfg_first);
        send_word(cfg_second);
        send_word(cfg_type);
        wait_drain();
    endtask

    task automatic test_short_lengths();
        set_config(8'hAA, 8'h55, 8'h02, 8'd0);
        send_frame(0, 1'b0);
        set_config(8'hAA, 8'h55, 8'h02, 8'd1);
        send_frame(0, 1'b1);
        wait_drain();
    endtask

    task automatic test_extreme_config();
        set_config(8'hFF, 8'h00, 8'hFF, 8'd3);
        send_frame(1, 1'b0);
        wait_drain();
    endtask

    task automatic test_length_change_mid_frame();
        set_config(8'hAA, 8'h55, 8'h02, 8'd8);
        send_word(cfg_first);
        send_word(cfg_second);
        send_word(cfg_type);
        send_word(8'h5A);
        send_word(8'hC3);
        wait_drain();
        // count already past the new length, so the next word closes the frame
        write_reg(REG_FRAME_LENGTH, 8'd2);
        send_word(8'h02 ^ 8'h5A ^ 8'hC3);
        wait_drain();
    endtask

    task automatic test_backpressure();
        set_config(8'h3C, 8'hC3, 8'h11, 8'd10);
        hold_req = 300;
        repeat (5)
            send_frame(8, 1'b0);
        // sender pauses here until the held words are all out
        wait_drain();
    endtask

    task automatic test_random_phases(input int target);
        int phase_idx;
        int phase_end;
        int r;
        logic [7:0] f, s, t, l;
        phase_idx = 0;
        while (words_sent < target)
        begin
            case (phase_idx)
                0:
                begin
                    f = FirstSyncRst;
                    s = SecondSyncRst;
                    t = FrameTypeRst;
                    l = FrameLengthRst;
                end
                1:
                begin
                    f = 8'h00;
                    s = 8'h00;
                    t = 8'h00;
                    l = 8'd2;
                end
                2:
                begin
                    f = 8'hFF;
                    s = 8'hFF;
                    t = 8'hFF;
                    l = 8'd255;
                end
                default:
                begin
                    f = 8'($urandom_range(0, 255));
                    s = 8'($urandom_range(0, 255));
                    t = 8'($urandom_range(0, 255));
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        l = 8'($urandom_range(0, 1));
                    else if (r == 1)
                        l = 8'($urandom_range(32, 255));
                    else
                        l = 8'($urandom_range(2, 12));
                end
            endcase
            set_config(f, s, t, l);
            tx_stall_on = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            phase_end = words_sent + $urandom_range(80, 200);
            while (words_sent < phase_end && words_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    send_frame(body_for_len(), $urandom_range(0, 3) == 0);
                end
                else if (r < 80)
                begin
                    send_word(cfg_first);
                    if ($urandom_range(0, 1))
                        send_word(cfg_second);
                    send_word(8'($urandom_range(0, 255)));
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        send_word(8'($urandom_range(0, 255)));
                end
            end
            wait_drain();
            phase_idx++;
        end
    endtask

    task automatic test_streaming();
        tx_stall_on = 1'b0;
        rx_stall_on = 1'b0;
        set_config(8'h7E, 8'h81, 8'h40, 8'd6);
        repeat (25)
            send_frame(4, $urandom_range(0, 4) == 0);
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_stall_on = 1'b1;
        rx_stall_on = 1'b1;
        test_hunting();
        test_short_lengths();
        test_extreme_config();
        test_length_change_mid_frame();
        test_backpressure();
        test_random_phases(TARGET_WORDS);
        test_streaming();
        repeat (10) @(posedge clk);
        $display("covered %0d input words, %0d result words, %0d register writes",
                 words_sent, results_checked, reg_writes);
        $display("frames closed: %0d with good checksum, %0d with bad checksum",
                 frames_good, frames_bad);
        if (fail_count == 0)
        begin
            $display("** sync_frame_xor_deframer: PASSED **");
        end
        else
        begin
            $display("** sync_frame_xor_deframer: FAILED **");
        end
        $finish;
    end

endmodule

### sync_frame_xor_deframer.f
+incdir+rtl
rtl/sfx_pkg.sv
rtl/sfx_cfg.sv
rtl/sfx_step.sv
rtl/sync_frame_xor_deframer.sv
bench/sync_frame_xor_deframer_tb.sv
